// ----- hw/rtl/edf_pkg.sv -----
// Package for the EDF task list manager: widths, action and status codes.
// No dependencies.
package edf_pkg;
  localparam int MaxTasks     = 16;
  localparam int DeadlineBits = 32;
  localparam int IdxW         = $clog2(MaxTasks);
  localparam int CntW         = $clog2(MaxTasks + 1);

  typedef logic [3:0]              task_id_t;
  typedef logic [DeadlineBits-1:0] deadline_t;
  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [CntW-1:0]         cnt_t;

  localparam logic [2:0] ActInsert    = 3'd0;
  localparam logic [2:0] ActExtract   = 3'd1;
  localparam logic [2:0] ActResched   = 3'd2;
  localparam logic [2:0] ActToWait    = 3'd3;
  localparam logic [2:0] ActWaitReady = 3'd4;
  localparam logic [2:0] ActToTimer   = 3'd5;
  localparam logic [2:0] ActTimerRdy  = 3'd6;
  localparam logic [2:0] ActNop       = 3'd7;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    task_id_t   task_id;
    deadline_t  deadline;
  } edf_in_t;

  typedef struct packed {
    task_id_t   running_task;
    logic       running_is_idle;
    task_id_t   moved_task;
    logic [1:0] status;
  } edf_out_t;
endpackage

// ----- hw/rtl/edf_if.sv -----
// Valid/ready channel interfaces for the EDF task list manager.
// Depends on edf_pkg.
interface edf_in_if;
  import edf_pkg::*;
  logic    valid;
  logic    ready;
  edf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edf_out_if;
  import edf_pkg::*;
  logic     valid;
  logic     ready;
  edf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/edf_task_list_manager.sv -----
// EDF task list manager: sorted ready queue, waiting and timer lists.
// Depends on edf_pkg and edf_if.
// One item at a time. A sequencer walks the lists one entry per cycle: a
// search of a source list, a one-slot shift per cycle for pops and list
// removals, then a sorted insert that scans from the tail, moving one entry
// up per cycle with a single deadline comparator. The longest item is a move
// back to ready, which searches, shifts and inserts. The result sits in an
// output register and the next item is taken once it has been transferred.
module edf_task_list_manager (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  edf_pkg::task_id_t cfg_wdata,
  edf_in_if.sink            in_ch,
  edf_out_if.source         out_ch
);
  import edf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_RMLIST = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  task_id_t  rdy_id [MaxTasks];
  deadline_t rdy_dl [MaxTasks];
  task_id_t  wt_id  [MaxTasks];
  task_id_t  tm_id  [MaxTasks];
  cnt_t      rdy_cnt, wt_cnt, tm_cnt;
  task_id_t  idle_id;

  logic [2:0] state;
  task_id_t   tid;
  deadline_t  dl;
  cnt_t       ptr;
  logic       use_tm;
  logic       reins;
  task_id_t   moved;
  logic [1:0] st;
  logic       out_valid;
  edf_out_t   out_data;

  cnt_t     src_cnt;
  task_id_t src_entry;
  idx_t     p_idx;
  idx_t     pm1;
  always_comb begin
    src_cnt   = use_tm ? tm_cnt : wt_cnt;
    p_idx     = ptr[IdxW-1:0];
    pm1       = p_idx - idx_t'(1);
    src_entry = use_tm ? tm_id[p_idx] : wt_id[p_idx];
  end

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rdy_cnt   <= '0;
      wt_cnt    <= '0;
      tm_cnt    <= '0;
      idle_id   <= 4'd15;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) idle_id <= cfg_wdata;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            tid    <= in_ch.data.task_id;
            dl     <= in_ch.data.deadline;
            moved  <= '0;
            st     <= StOk;
            reins  <= 1'b0;
            use_tm <= (in_ch.data.action == ActToTimer) ||
                      (in_ch.data.action == ActTimerRdy);
            ptr    <= '0;
            case (in_ch.data.action)
              ActInsert: begin
                if (rdy_cnt == cnt_t'(MaxTasks)) begin
                  st    <= StFull;
                  state <= S_DONE;
                end else begin
                  moved <= in_ch.data.task_id;
                  ptr   <= rdy_cnt;
                  state <= S_INS;
                end
              end
              ActExtract, ActResched: begin
                if (rdy_cnt == '0) begin
                  st    <= StEmpty;
                  state <= S_DONE;
                end else begin
                  moved <= rdy_id[0];
                  tid   <= rdy_id[0];
                  reins <= in_ch.data.action == ActResched;
                  ptr   <= cnt_t'(1);
                  state <= S_POP;
                end
              end
              ActToWait, ActToTimer: begin
                if (rdy_cnt == '0) begin
                  st    <= StEmpty;
                  state <= S_DONE;
                end else if ((in_ch.data.action == ActToWait ? wt_cnt : tm_cnt)
                             == cnt_t'(MaxTasks)) begin
                  st    <= StFull;
                  state <= S_DONE;
                end else begin
                  moved <= rdy_id[0];
                  if (in_ch.data.action == ActToWait) begin
                    wt_id[wt_cnt[IdxW-1:0]] <= rdy_id[0];
                    wt_cnt <= wt_cnt + cnt_t'(1);
                  end else begin
                    tm_id[tm_cnt[IdxW-1:0]] <= rdy_id[0];
                    tm_cnt <= tm_cnt + cnt_t'(1);
                  end
                  ptr   <= cnt_t'(1);
                  state <= S_POP;
                end
              end
              ActWaitReady, ActTimerRdy: state <= S_SEARCH;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          if (ptr == src_cnt) begin
            st    <= StNotFound;
            state <= S_DONE;
          end else if (src_entry == tid) begin
            if (rdy_cnt == cnt_t'(MaxTasks)) begin
              st    <= StFull;
              state <= S_DONE;
            end else begin
              ptr   <= ptr + cnt_t'(1);
              state <= S_RMLIST;
            end
          end else begin
            ptr <= ptr + cnt_t'(1);
          end
        end
        S_RMLIST: begin
          // shift later entries down over the found slot
          if (ptr == src_cnt) begin
            if (use_tm) tm_cnt <= tm_cnt - cnt_t'(1);
            else wt_cnt <= wt_cnt - cnt_t'(1);
            moved <= tid;
            ptr   <= rdy_cnt;
            state <= S_INS;
          end else begin
            if (use_tm) tm_id[pm1] <= tm_id[p_idx];
            else wt_id[pm1] <= wt_id[p_idx];
            ptr <= ptr + cnt_t'(1);
          end
        end
        S_POP: begin
          if (ptr == rdy_cnt) begin
            rdy_cnt <= rdy_cnt - cnt_t'(1);
            ptr     <= rdy_cnt - cnt_t'(1);
            state   <= reins ? S_INS : S_DONE;
          end else begin
            rdy_id[pm1] <= rdy_id[p_idx];
            rdy_dl[pm1] <= rdy_dl[p_idx];
            ptr <= ptr + cnt_t'(1);
          end
        end
        S_INS: begin
          // scan from tail; entries later than dl move up one slot
          if (ptr != '0 && rdy_dl[pm1] > dl) begin
            rdy_id[p_idx] <= rdy_id[pm1];
            rdy_dl[p_idx] <= rdy_dl[pm1];
            ptr <= ptr - cnt_t'(1);
          end else begin
            rdy_id[p_idx] <= tid;
            rdy_dl[p_idx] <= dl;
            rdy_cnt <= rdy_cnt + cnt_t'(1);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_data.running_is_idle <= rdy_cnt == '0;
          out_data.running_task <= (rdy_cnt == '0) ? idle_id : rdy_id[0];
          out_data.moved_task <= moved;
          out_data.status <= st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rdy_cnt <= cnt_t'(MaxTasks) && wt_cnt <= cnt_t'(MaxTasks) &&
    tm_cnt <= cnt_t'(MaxTasks)) else $error("list count overflow");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_idle_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.running_is_idle == (rdy_cnt == '0)))
    else $error("idle flag mismatch");
  a_bad_moved: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != StOk) |-> out_data.moved_task == '0)
    else $error("moved task on error");
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for edf_task_list_manager: directed table, then random scheduling.
// Depends on edf_pkg, edf_if and the block's RTL.
module tb_top;
  import edf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  task_id_t cfg_wdata = '0;

  always #5 clk = ~clk;

  edf_in_if  in_ch ();
  edf_out_if out_ch ();

  edf_task_list_manager DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // scheduler shadow state
  task_id_t  rq_id [MaxTasks];
  deadline_t rq_dl [MaxTasks];
  int        rq_n;
  task_id_t  wl_id [MaxTasks];
  int        wl_n;
  task_id_t  tl_id [MaxTasks];
  int        tl_n;
  task_id_t  idle_id;

  edf_out_t sched_results[$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  bit  timed_out = 1'b0;

  typedef struct {
    logic [2:0] action;
    task_id_t   tid;
    deadline_t  dl;
    bit         has_exp;
    edf_out_t   exp;
  } stim_row_t;

  function automatic void ready_put(task_id_t id, deadline_t dl);
    int pos;
    pos = 0;
    while (pos < rq_n && rq_dl[pos] <= dl) pos++;
    for (int i = rq_n; i > pos; i--) begin
      rq_id[i] = rq_id[i-1];
      rq_dl[i] = rq_dl[i-1];
    end
    rq_id[pos] = id;
    rq_dl[pos] = dl;
    rq_n++;
  endfunction

  function automatic task_id_t ready_take();
    task_id_t id;
    id = rq_id[0];
    for (int i = 1; i < rq_n; i++) begin
      rq_id[i-1] = rq_id[i];
      rq_dl[i-1] = rq_dl[i];
    end
    rq_n--;
    return id;
  endfunction

  function automatic edf_out_t schedule(edf_in_t it);
    edf_out_t r;
    int pos;
    r = '0;
    r.status = StOk;
    case (it.action)
      ActInsert: begin
        if (rq_n >= MaxTasks) r.status = StFull;
        else begin
          ready_put(it.task_id, it.deadline);
          r.moved_task = it.task_id;
        end
      end
      ActExtract: begin
        if (rq_n == 0) r.status = StEmpty;
        else r.moved_task = ready_take();
      end
      ActResched: begin
        if (rq_n == 0) r.status = StEmpty;
        else begin
          r.moved_task = ready_take();
          ready_put(r.moved_task, it.deadline);
        end
      end
      ActToWait, ActToTimer: begin
        if (rq_n == 0) r.status = StEmpty;
        else if ((it.action == ActToWait ? wl_n : tl_n) >= MaxTasks) r.status = StFull;
        else begin
          r.moved_task = ready_take();
          if (it.action == ActToWait) begin
            wl_id[wl_n] = r.moved_task;
            wl_n++;
          end else begin
            tl_id[tl_n] = r.moved_task;
            tl_n++;
          end
        end
      end
      ActWaitReady: begin
        pos = 0;
        while (pos < wl_n && wl_id[pos] != it.task_id) pos++;
        if (pos >= wl_n) r.status = StNotFound;
        else if (rq_n >= MaxTasks) r.status = StFull;
        else begin
          for (int i = pos + 1; i < wl_n; i++) wl_id[i-1] = wl_id[i];
          wl_n--;
          ready_put(it.task_id, it.deadline);
          r.moved_task = it.task_id;
        end
      end
      ActTimerRdy: begin
        pos = 0;
        while (pos < tl_n && tl_id[pos] != it.task_id) pos++;
        if (pos >= tl_n) r.status = StNotFound;
        else if (rq_n >= MaxTasks) r.status = StFull;
        else begin
          for (int i = pos + 1; i < tl_n; i++) tl_id[i-1] = tl_id[i];
          tl_n--;
          ready_put(it.task_id, it.deadline);
          r.moved_task = it.task_id;
        end
      end
      default: ;
    endcase
    if (rq_n > 0) begin
      r.running_task = rq_id[0];
      r.running_is_idle = 1'b0;
    end else begin
      r.running_task = idle_id;
      r.running_is_idle = 1'b1;
    end
    return r;
  endfunction

  // sender side; valid stays up after a transfer until the next gap or drain
  task automatic send_item(logic [2:0] act, task_id_t tid, deadline_t dl);
    edf_in_t it;
    it.action = act;
    it.task_id = tid;
    it.deadline = dl;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sched_results.push_back(schedule(it));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
    repeat (2 * MaxTasks + 8) @(posedge clk);
  endtask

  task automatic set_idle(task_id_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_id = v;
  endtask

  function automatic deadline_t rand_dl();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return deadline_t'($urandom_range(0, 7));
      default: return deadline_t'($urandom);
    endcase
  endfunction

  // receiver side: random stall bursts, checks each transfer
  initial begin
    edf_out_t exp;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (sched_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          exp = sched_results.pop_front();
          if (out_ch.data !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch run/idle/moved/st: exp %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
                exp.running_task, exp.running_is_idle, exp.moved_task, exp.status,
                out_ch.data.running_task, out_ch.data.running_is_idle,
                out_ch.data.moved_task, out_ch.data.status);
          end
        end
      end
    end
  end

  initial begin
    #40000000;
    timed_out = 1'b1;
    $display("[edf_task_list_manager] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int fill;
    int dir;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rq_n = 0; wl_n = 0; tl_n = 0;
    idle_id = 4'd15;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue cases after reset, then ties, extremes and unknown tasks
    rows.push_back('{ActExtract,   4'd0,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StEmpty}});
    rows.push_back('{ActResched,   4'd0,  32'd5, 1, '{4'd15, 1'b1, 4'd0, StEmpty}});
    rows.push_back('{ActToWait,    4'd0,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StEmpty}});
    rows.push_back('{ActToTimer,   4'd0,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StEmpty}});
    rows.push_back('{ActWaitReady, 4'd3,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StNotFound}});
    rows.push_back('{ActTimerRdy,  4'd3,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StNotFound}});
    rows.push_back('{ActNop,       4'd9,  32'd0, 1, '{4'd15, 1'b1, 4'd0, StOk}});
    rows.push_back('{ActInsert,    4'd0,  '1,    1, '{4'd0, 1'b0, 4'd0, StOk}});
    rows.push_back('{ActInsert,    4'd15, '0,    1, '{4'd15, 1'b0, 4'd15, StOk}});
    rows.push_back('{ActInsert,    4'd5,  '0,    0, '0});
    rows.push_back('{ActInsert,    4'd6,  32'd100, 0, '0});
    rows.push_back('{ActInsert,    4'd7,  32'd100, 0, '0});
    rows.push_back('{ActResched,   4'd0,  32'd100, 0, '0});
    rows.push_back('{ActToWait,    4'd0,  32'd0, 0, '0});
    rows.push_back('{ActToTimer,   4'd0,  32'd0, 0, '0});
    rows.push_back('{ActToWait,    4'd0,  32'd0, 0, '0});
    rows.push_back('{ActWaitReady, 4'd5,  32'd50, 0, '0});
    rows.push_back('{ActTimerRdy,  4'd5,  32'd0, 0, '0});
    rows.push_back('{ActWaitReady, 4'd15, '1,    0, '0});
    rows.push_back('{ActTimerRdy,  4'd15, 32'd7, 0, '0});
    rows.push_back('{ActExtract,   4'd0,  32'd0, 0, '0});
    rows.push_back('{ActNop,       4'd0,  32'd0, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_exp) begin
        // typed-in value must agree with the predictor as well
        send_item(row.action, row.tid, row.dl);
        if (sched_results[$] !== row.exp) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with prediction", i);
        end
      end else send_item(row.action, row.tid, row.dl);
    end

    // fill every list to its limit; hits the ready queue's full cases
    set_idle(4'd0);
    for (int i = 0; i < MaxTasks + 2; i++) send_item(ActInsert, 4'(i), rand_dl());
    for (int i = 0; i < MaxTasks + 2; i++) send_item(ActToWait, 4'd0, '0);
    for (int i = 0; i < MaxTasks; i++) send_item(ActInsert, 4'(i), rand_dl());
    send_item(ActWaitReady, 4'd3, 32'd1);
    for (int i = 0; i < MaxTasks + 2; i++) send_item(ActToTimer, 4'd0, '0);
    for (int i = 0; i < MaxTasks; i++) send_item(ActInsert, 4'(i), rand_dl());
    send_item(ActTimerRdy, 4'd3, 32'd1);

    // pause until the block has delivered everything
    drain();
    set_idle(4'd15);

    // random part: mostly legal moves of real tasks, some noise
    for (int n = 0; n < 940; n++) begin
      logic [2:0] act;
      task_id_t tid;
      if (n == 350) set_idle(task_id_t'($urandom_range(0, 15)));
      if (n == 700) set_idle(4'd0);
      if (n == 900) no_idle = 1'b1;
      dir = $urandom_range(0, 99);
      fill = rq_n;
      if (dir < 8) act = 3'($urandom_range(0, 7));
      else if (dir < 30 && fill < 12) act = ActInsert;
      else act = 3'($urandom_range(0, 6));
      tid = task_id_t'($urandom);
      if (act == ActWaitReady && wl_n > 0 && $urandom_range(0, 4) != 0)
        tid = wl_id[$urandom_range(0, wl_n - 1)];
      if (act == ActTimerRdy && tl_n > 0 && $urandom_range(0, 4) != 0)
        tid = tl_id[$urandom_range(0, tl_n - 1)];
      send_item(act, tid, rand_dl());
    end

    drain();
    if (mismatches == 0 && !timed_out) $display("[edf_task_list_manager] OK");
    else $display("[edf_task_list_manager] ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/edf_pkg.sv
hw/rtl/edf_if.sv
hw/rtl/edf_task_list_manager.sv
tb/tb_top.sv
